// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: label");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: label");

// Next-cycle implication checked at every edge, reset included.
`define ASSERT_NEXT_ALWAYS(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("assertion failed: label");

`endif

// File: design/rhsv_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV package
// Constants, the classified item type and the divider step shared by the unit.
// ----------------------------------------------------------------------------
package rhsv_pkg;

   localparam int unsigned CHAN_BITS  = 8;
   localparam int unsigned QUO_BITS   = 8;
   localparam int unsigned REM_BITS   = 16;
   localparam int unsigned SHIFT_BITS = $clog2(QUO_BITS);

   localparam int unsigned FIFO_DEPTH_DEFAULT = 4;

   localparam logic [CHAN_BITS-1:0] SAT_FULL     = 8'd255;
   localparam logic [CHAN_BITS-1:0] HUE_SPAN     = 8'd43;
   localparam logic [CHAN_BITS-1:0] HUE_BASE_RED = 8'd0;
   localparam logic [CHAN_BITS-1:0] HUE_BASE_GRN = 8'd85;
   localparam logic [CHAN_BITS-1:0] HUE_BASE_BLU = 8'd171;

   // One pixel after classification, ready for the two divisions.
   typedef struct packed {
      logic [REM_BITS-1:0]  sat_num;   // 255 * spread
      logic [CHAN_BITS-1:0] sat_div;   // maximum channel
      logic [REM_BITS-1:0]  hue_num;   // 43 * |channel difference|
      logic [CHAN_BITS-1:0] hue_div;   // spread
      logic [CHAN_BITS-1:0] base;      // sector base
      logic                 neg;       // channel difference is negative
      logic                 zero;      // grey or black pixel
      logic [CHAN_BITS-1:0] value;
   } rhsv_item_type;

   typedef struct packed {
      logic [REM_BITS-1:0] rem;
      logic                quo_bit;
   } rhsv_step_type;

   // One restoring division step against the divisor shifted by the given amount.
   function automatic rhsv_step_type div_step(input logic [REM_BITS-1:0]   rem,
                                              input logic [CHAN_BITS-1:0]  dvs,
                                              input logic [SHIFT_BITS-1:0] shift);
      logic [REM_BITS-1:0] trial;
      rhsv_step_type       res;
      trial = REM_BITS'(dvs) << shift;
      if (rem >= trial) begin
         res.rem     = rem - trial;
         res.quo_bit = 1'b1;
      end else begin
         res.rem     = rem;
         res.quo_bit = 1'b0;
      end
      return res;
   endfunction

endpackage

// File: design/rgb_to_hsv_8bit_unit.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter, 8 bits per channel
// Streams RGB pixels in and HSV pixels out, one transaction per clock when nothing stalls.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                   Direction   Moves
//   req       req_valid/ready, req_red/green/blue     in          one RGB pixel
//   rsp       rsp_valid/ready, rsp_hue/saturation/    out         one HSV pixel
//             rsp_value
//
// One transaction is accepted per clock when nothing stalls; the rate is set by
// the divider pipeline, which advances a stage whenever its content moves on.
// A pixel passes the queue register, the eight divider stages and the output
// register, in that order, before it shows on rsp.
// Reset (synchronous, active high) empties the queue and the pipeline.
// A stall on rsp backs up through the pipeline into the queue; req_ready drops
// only once the queue is full.
//
// The front end classifies each pixel: the maximum channel is the value, the
// spread is max minus min, and the sector (red, green, blue, checked in that
// order on ties) gives the hue base and the signed difference of the other two
// channels. The back end divides 255*spread by max for saturation and
// 43*|difference| by spread for the hue offset, both as restoring dividers
// resolving one quotient bit per stage. Because the hue quotient is formed from
// the magnitude, applying the sign afterwards gives truncation toward zero.
// A grey or black pixel (zero spread) forces hue and saturation to zero.
// ----------------------------------------------------------------------------
module rgb_to_hsv_8bit_unit #(
   parameter int unsigned DEPTH = rhsv_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rhsv_pkg::CHAN_BITS-1:0] req_red,
   input  logic [rhsv_pkg::CHAN_BITS-1:0] req_green,
   input  logic [rhsv_pkg::CHAN_BITS-1:0] req_blue,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rhsv_pkg::CHAN_BITS-1:0] rsp_hue,
   output logic [rhsv_pkg::CHAN_BITS-1:0] rsp_saturation,
   output logic [rhsv_pkg::CHAN_BITS-1:0] rsp_value
);
   import rhsv_pkg::*;

   rhsv_item_type front_item;
   rhsv_item_type queue_item;
   logic          queue_valid;
   logic          queue_ready;

   // Classification is combinational; the queue registers its result.
   rhsv_front u_front (
      .red   (req_red),
      .green (req_green),
      .blue  (req_blue),
      .item  (front_item)
   );

   rhsv_fifo #(
      .DEPTH (DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   rhsv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (queue_valid),
      .item_ready     (queue_ready),
      .item           (queue_item),
      .out_valid      (rsp_valid),
      .out_ready      (rsp_ready),
      .out_hue        (rsp_hue),
      .out_saturation (rsp_saturation),
      .out_value      (rsp_value)
   );

endmodule

// File: design/rhsv_front.sv
// ----------------------------------------------------------------------------
// RGB to HSV front end
// Finds maximum, minimum and sector of a pixel and forms the division operands.
// ----------------------------------------------------------------------------
module rhsv_front (
   input  logic [rhsv_pkg::CHAN_BITS-1:0] red,
   input  logic [rhsv_pkg::CHAN_BITS-1:0] green,
   input  logic [rhsv_pkg::CHAN_BITS-1:0] blue,
   output rhsv_pkg::rhsv_item_type        item
);
   import rhsv_pkg::*;

   logic [CHAN_BITS-1:0] hi;
   logic [CHAN_BITS-1:0] lo;
   logic [CHAN_BITS-1:0] spread;
   logic [CHAN_BITS:0]   diff;
   logic [CHAN_BITS-1:0] mag;

   always_comb begin
      lo = (red < green) ? red : green;
      if (blue < lo) begin
         lo = blue;
      end
      // Ties go to red first, then green.
      if (red >= green && red >= blue) begin
         hi        = red;
         item.base = HUE_BASE_RED;
         diff      = {1'b0, green} - {1'b0, blue};
      end else if (green >= blue) begin
         hi        = green;
         item.base = HUE_BASE_GRN;
         diff      = {1'b0, blue} - {1'b0, red};
      end else begin
         hi        = blue;
         item.base = HUE_BASE_BLU;
         diff      = {1'b0, red} - {1'b0, green};
      end
      spread = hi - lo;
      mag    = diff[CHAN_BITS] ? CHAN_BITS'(-diff) : diff[CHAN_BITS-1:0];

      item.sat_num = REM_BITS'(spread) * REM_BITS'(SAT_FULL);
      item.sat_div = hi;
      item.hue_num = REM_BITS'(mag) * REM_BITS'(HUE_SPAN);
      item.hue_div = spread;
      item.neg     = diff[CHAN_BITS];
      item.zero    = (spread == '0);
      item.value   = hi;
   end

endmodule

// File: design/rhsv_fifo.sv
// ----------------------------------------------------------------------------
// RGB to HSV item queue
// Short register queue between the front end and the divider pipeline.
// ----------------------------------------------------------------------------
module rhsv_fifo #(
   parameter int unsigned DEPTH = rhsv_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  rhsv_pkg::rhsv_item_type push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output rhsv_pkg::rhsv_item_type pop_item
);
   import rhsv_pkg::*;

   localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

   rhsv_item_type       mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != CNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: design/rhsv_back.sv
// ----------------------------------------------------------------------------
// RGB to HSV back end
// Stallable pipeline of restoring divider steps, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rhsv_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           item_valid,
   output logic                           item_ready,
   input  rhsv_pkg::rhsv_item_type        item,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [rhsv_pkg::CHAN_BITS-1:0] out_hue,
   output logic [rhsv_pkg::CHAN_BITS-1:0] out_saturation,
   output logic [rhsv_pkg::CHAN_BITS-1:0] out_value
);
   import rhsv_pkg::*;

   typedef struct packed {
      logic [REM_BITS-1:0]  rem_s;
      logic [CHAN_BITS-1:0] div_s;
      logic [QUO_BITS-1:0]  quo_s;
      logic [REM_BITS-1:0]  rem_h;
      logic [CHAN_BITS-1:0] div_h;
      logic [QUO_BITS-1:0]  quo_h;
      logic [CHAN_BITS-1:0] base;
      logic                 neg;
      logic                 zero;
      logic [CHAN_BITS-1:0] value;
   } stage_type;

   stage_type            stage_ff [QUO_BITS];
   stage_type            stepped  [QUO_BITS];
   logic [QUO_BITS-1:0]  valid_ff;
   logic [QUO_BITS:0]    take;
   stage_type            entry;
   stage_type            last;
   logic                 out_valid_ff;
   logic [CHAN_BITS-1:0] hue_ff, hue_in;
   logic [CHAN_BITS-1:0] sat_ff, sat_in;
   logic [CHAN_BITS-1:0] value_ff;

   // Stage i takes a new entry when it is empty or its content moves on.
   always_comb begin
      take[QUO_BITS] = !out_valid_ff || out_ready;
      for (int i = QUO_BITS - 1; i >= 0; i--) begin
         take[i] = !valid_ff[i] || take[i+1];
      end
   end

   assign item_ready = take[0];

   always_comb begin
      entry.rem_s = item.sat_num;
      entry.div_s = item.sat_div;
      entry.quo_s = '0;
      entry.rem_h = item.hue_num;
      entry.div_h = item.hue_div;
      entry.quo_h = '0;
      entry.base  = item.base;
      entry.neg   = item.neg;
      entry.zero  = item.zero;
      entry.value = item.value;
   end

   // Stage i resolves quotient bit QUO_BITS-1-i of both divisions.
   always_comb begin
      rhsv_step_type ss, sh;
      for (int i = 0; i < QUO_BITS; i++) begin
         ss = div_step(stage_ff[i].rem_s, stage_ff[i].div_s,
                       SHIFT_BITS'(QUO_BITS - 1 - i));
         sh = div_step(stage_ff[i].rem_h, stage_ff[i].div_h,
                       SHIFT_BITS'(QUO_BITS - 1 - i));
         stepped[i]       = stage_ff[i];
         stepped[i].rem_s = ss.rem;
         stepped[i].quo_s = {stage_ff[i].quo_s[QUO_BITS-2:0], ss.quo_bit};
         stepped[i].rem_h = sh.rem;
         stepped[i].quo_h = {stage_ff[i].quo_h[QUO_BITS-2:0], sh.quo_bit};
      end
   end

   assign last = stepped[QUO_BITS-1];

   always_comb begin
      if (last.zero) begin
         hue_in = '0;
         sat_in = '0;
      end else begin
         hue_in = last.neg ? last.base - CHAN_BITS'(last.quo_h)
                           : last.base + CHAN_BITS'(last.quo_h);
         sat_in = CHAN_BITS'(last.quo_s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take[0]) begin
            valid_ff[0] <= item_valid;
         end
         for (int i = 1; i < QUO_BITS; i++) begin
            if (take[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
         if (take[QUO_BITS]) begin
            out_valid_ff <= valid_ff[QUO_BITS-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take[0]) begin
         stage_ff[0] <= entry;
      end
      for (int i = 1; i < QUO_BITS; i++) begin
         if (take[i]) begin
            stage_ff[i] <= stepped[i-1];
         end
      end
      if (take[QUO_BITS]) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         value_ff <= last.value;
      end
   end

   assign out_valid      = out_valid_ff;
   assign out_hue        = hue_ff;
   assign out_saturation = sat_ff;
   assign out_value      = value_ff;

endmodule

// File: design/rhsv_checker.sv
// ----------------------------------------------------------------------------
// RGB to HSV port checker
// Watches the converter ports for reset, surplus, stall and special cases.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rhsv_checker #(
   parameter int unsigned DEPTH = rhsv_pkg::FIFO_DEPTH_DEFAULT
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [rhsv_pkg::CHAN_BITS-1:0] rsp_hue,
   input logic [rhsv_pkg::CHAN_BITS-1:0] rsp_saturation,
   input logic [rhsv_pkg::CHAN_BITS-1:0] rsp_value
);
   import rhsv_pkg::*;

   // Pixels in flight: queue, divider stages and the output register.
   localparam int unsigned CNT_BITS = $clog2(DEPTH + QUO_BITS + 2);

   logic [CNT_BITS-1:0]    pending_ff, pending_in;
   logic                   req_take, rsp_take;
   logic                   rsp_black, rsp_stall;
   logic [3*CHAN_BITS-1:0] rsp_hsv;

   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid && rsp_ready;
   assign rsp_black = rsp_valid && rsp_value == '0;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_hsv   = {rsp_hue, rsp_saturation, rsp_value};

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `ASSERT_NEXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_valid)

   `ASSERT_IMPLY(a_no_invented_rsp, clock, reset, rsp_valid, pending_ff != '0)

   `ASSERT_IMPLY(a_black_pixel, clock, reset, rsp_black, {rsp_hue, rsp_saturation} == '0)

   `ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_stall, rsp_valid && $stable(rsp_hsv))

endmodule

bind rgb_to_hsv_8bit_unit rhsv_checker #(
   .DEPTH (DEPTH)
) u_rhsv_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hue        (rsp_hue),
   .rsp_saturation (rsp_saturation),
   .rsp_value      (rsp_value)
);

// File: tb/rgb_to_hsv_8bit_unit_tb.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Streams RGB pixels through the unit under random flow control and checks
// every HSV result against a behavioral conversion computed in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_to_hsv_8bit_unit_tb;

   import rhsv_pkg::*;

   localparam int RANDOM_PIXELS = 1600;
   localparam int MAX_REPORTS   = 10;
   localparam int TAIL_CYCLES   = 20;
   localparam int RESET_CYCLES  = 7;

   // One RGB pixel as it enters the unit, one HSV pixel as it leaves.
   typedef struct packed {
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
   } rgb_pixel_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] hue;
      logic [CHAN_BITS-1:0] saturation;
      logic [CHAN_BITS-1:0] value;
   } hsv_pixel_type;

   // Flow-control phases: who idles and how often.
   typedef enum logic [1:0] {
      PH_RECV_HEAVY,   // sender idles 34 %, receiver 48 %
      PH_SEND_HEAVY,   // sender idles 48 %, receiver 34 %
      PH_FULL_RATE     // neither side idles
   } flow_phase_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [CHAN_BITS-1:0] req_red = '0;
   logic [CHAN_BITS-1:0] req_green = '0;
   logic [CHAN_BITS-1:0] req_blue = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CHAN_BITS-1:0] rsp_hue;
   logic [CHAN_BITS-1:0] rsp_saturation;
   logic [CHAN_BITS-1:0] rsp_value;

   rgb_pixel_type  pixels_to_send[$];
   hsv_pixel_type  expected_hsv[$];
   rgb_pixel_type  next_pixel;
   hsv_pixel_type  want_hsv;
   flow_phase_type phase = PH_RECV_HEAVY;

   int total_pixels   = 0;
   int directed_count = 0;
   int mid_drain_at   = 0;
   int sent_count     = 0;   // driver only
   int accepted_count = 0;   // updated with nonblocking assignments
   int result_count   = 0;   // updated with nonblocking assignments
   int mismatch_count = 0;
   int error_count    = 0;

   rgb_to_hsv_8bit_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_value      (rsp_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Integer conversion of one pixel. The hue offset divides a signed
   // difference, and SystemVerilog integer division truncates toward zero,
   // which is the behavior the unit must reproduce. Hue wraps modulo 256.
   function automatic hsv_pixel_type convert_to_hsv(input rgb_pixel_type px);
      int            r, g, b;
      int            hi, lo, spread, sat, base, diff, off, hue_sum;
      hsv_pixel_type res;
      r  = px.red;
      g  = px.green;
      b  = px.blue;
      hi = (r > g) ? r : g;
      if (b > hi) hi = b;
      lo = (r < g) ? r : g;
      if (b < lo) lo = b;
      res = '0;
      res.value = hi[CHAN_BITS-1:0];
      // A black pixel has neither hue nor saturation.
      if (hi == 0) return res;
      spread = hi - lo;
      sat    = (int'(SAT_FULL) * spread) / hi;
      res.saturation = sat[CHAN_BITS-1:0];
      // A grey pixel keeps its saturation of zero and gets no hue.
      if (sat == 0 || spread == 0) return res;
      // Ties on the maximum go to red first, then green, then blue.
      if (hi == r) begin
         base = HUE_BASE_RED;
         diff = g - b;
      end else if (hi == g) begin
         base = HUE_BASE_GRN;
         diff = b - r;
      end else begin
         base = HUE_BASE_BLU;
         diff = r - g;
      end
      // The span is taken as a signed int so that the product keeps its sign.
      off     = (int'(HUE_SPAN) * diff) / spread;
      hue_sum = base + off;
      res.hue = hue_sum[CHAN_BITS-1:0];
      return res;
   endfunction

   function automatic logic [CHAN_BITS-1:0] near_channel(input int centre);
      int c;
      c = centre + int'($urandom_range(0, 6)) - 3;
      if (c < 0) c = 0;
      if (c > 255) c = 255;
      return c[CHAN_BITS-1:0];
   endfunction

   function automatic logic [CHAN_BITS-1:0] extreme_channel();
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd254;
         default: return 8'd255;
      endcase
   endfunction

   task automatic add_pixel(input int r, input int g, input int b);
      rgb_pixel_type px;
      px.red   = r[CHAN_BITS-1:0];
      px.green = g[CHAN_BITS-1:0];
      px.blue  = b[CHAN_BITS-1:0];
      pixels_to_send.push_back(px);
   endtask

   // Stimulus: a directed set of corner pixels, then a random mix that leans
   // toward the interesting regions (close channels, ties, greys, extremes).
   initial begin : fill_pixels
      int mode, centre, c0, c1;
      add_pixel(0, 0, 0);         // black
      add_pixel(255, 255, 255);   // white, grey at the top
      add_pixel(128, 128, 128);   // mid grey
      add_pixel(1, 1, 1);         // darkest grey
      add_pixel(255, 0, 0);       // pure red
      add_pixel(0, 255, 0);       // pure green
      add_pixel(0, 0, 255);       // pure blue
      add_pixel(255, 255, 0);     // red and green tied, red wins
      add_pixel(0, 255, 255);     // green and blue tied, green wins
      add_pixel(255, 0, 255);     // red and blue tied, red wins
      add_pixel(255, 0, 43);      // red sector with a negative offset
      add_pixel(255, 0, 1);       // smallest negative offset in red
      add_pixel(255, 0, 254);     // near the wrap from red back to blue
      add_pixel(255, 254, 254);   // smallest saturation
      add_pixel(1, 0, 0);         // darkest red
      add_pixel(0, 1, 0);
      add_pixel(0, 0, 1);
      add_pixel(1, 0, 1);
      add_pixel(0, 1, 1);
      add_pixel(254, 255, 0);     // green sector, negative difference
      add_pixel(0, 254, 255);     // blue sector, negative difference
      add_pixel(170, 85, 255);
      add_pixel(85, 170, 0);
      directed_count = pixels_to_send.size();
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         mode = $urandom_range(0, 9);
         case (mode)
            0, 1, 2, 3: add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 255));
            4, 5: begin
               centre = $urandom_range(0, 255);
               add_pixel(near_channel(centre), near_channel(centre), near_channel(centre));
            end
            6: begin
               // Two channels tie; which pair is random.
               c0 = $urandom_range(0, 255);
               c1 = $urandom_range(0, 255);
               case ($urandom_range(0, 2))
                  0: add_pixel(c0, c0, c1);
                  1: add_pixel(c0, c1, c0);
                  default: add_pixel(c1, c0, c0);
               endcase
            end
            7: begin
               c0 = $urandom_range(0, 255);
               add_pixel(c0, c0, c0);
            end
            8: add_pixel($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
            default: add_pixel(extreme_channel(), extreme_channel(), extreme_channel());
         endcase
      end
      total_pixels = pixels_to_send.size();
      mid_drain_at = directed_count + RANDOM_PIXELS / 2;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   // Driver. A new transaction is offered only once the previous one has been
   // accepted or none is pending, so valid stays up with a steady payload.
   // At the end of the directed part and again halfway through the random
   // part the driver holds back until every outstanding result has returned.
   always @(posedge clock) begin : drive_pixels
      int idle_pct;
      logic hold_for_drain;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         case (phase)
            PH_RECV_HEAVY: idle_pct = 34;
            PH_SEND_HEAVY: idle_pct = 48;
            default:       idle_pct = 0;
         endcase
         hold_for_drain = (sent_count == directed_count || sent_count == mid_drain_at)
                          && result_count != sent_count;
         if (pixels_to_send.size() != 0 && !hold_for_drain
             && $urandom_range(0, 99) >= idle_pct) begin
            next_pixel = pixels_to_send.pop_front();
            req_valid <= 1'b1;
            req_red   <= next_pixel.red;
            req_green <= next_pixel.green;
            req_blue  <= next_pixel.blue;
            sent_count++;
            if (sent_count < total_pixels / 3)
               phase <= PH_RECV_HEAVY;
            else if (sent_count < (2 * total_pixels) / 3)
               phase <= PH_SEND_HEAVY;
            else
               phase <= PH_FULL_RATE;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor. Accepted requests are converted and queued in arrival order;
   // each accepted response is compared with the oldest queued conversion.
   always @(posedge clock) begin : check_results
      int recv_idle_pct;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         case (phase)
            PH_RECV_HEAVY: recv_idle_pct = 48;
            PH_SEND_HEAVY: recv_idle_pct = 34;
            default:       recv_idle_pct = 0;
         endcase
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

         if (req_valid && req_ready) begin
            expected_hsv.push_back(convert_to_hsv({req_red, req_green, req_blue}));
            accepted_count <= accepted_count + 1;
         end

         if (rsp_valid && rsp_ready) begin
            result_count <= result_count + 1;
            if (expected_hsv.size() == 0) begin
               error_count++;
               $display("ERROR: unexpected result transaction hue=%0d sat=%0d value=%0d",
                        rsp_hue, rsp_saturation, rsp_value);
            end else begin
               want_hsv = expected_hsv.pop_front();
               if (rsp_hue !== want_hsv.hue || rsp_saturation !== want_hsv.saturation
                   || rsp_value !== want_hsv.value) begin
                  error_count++;
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("MISMATCH result %0d: expected h/s/v %0d/%0d/%0d, got %0d/%0d/%0d",
                              result_count, want_hsv.hue, want_hsv.saturation,
                              want_hsv.value, rsp_hue, rsp_saturation, rsp_value);
               end
            end
         end
      end
   end

   // End of run: all pixels in, all results out, then a short tail so that a
   // stray extra result would still be caught.
   initial begin
      @(negedge reset);
      while (total_pixels == 0 || accepted_count != total_pixels
             || result_count != total_pixels)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_hsv.size() != 0) begin
         error_count += expected_hsv.size();
         $display("ERROR: %0d results never arrived", expected_hsv.size());
      end
      $display("Converted %0d pixels (%0d directed corners, the rest random) under three",
               result_count, directed_count);
      $display("flow-control phases with two full drains; %0d mismatches seen.",
               mismatch_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("TIMEOUT: run did not complete");
      $display("Some tests failed");
      $finish;
   end

endmodule
